// ----- sv/dhc_pkg.sv -----
// shared types, constants and helpers for the datagram header checker
package dhc_pkg;

    localparam int unsigned COUNT_W = 17;

    localparam logic [COUNT_W-1:0] HDR_BYTES = 17'd58;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [7:0]         HDR_VERSION = 8'd1;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_TYPE_LOW         = 2'd0;
    localparam logic [1:0] REG_TYPE_HIGH        = 2'd1;
    localparam logic [1:0] REG_MAX_COMPRESSED   = 2'd2;
    localparam logic [1:0] REG_MAX_UNCOMPRESSED = 2'd3;

    localparam logic [7:0]  RST_TYPE_LOW         = 8'd1;
    localparam logic [7:0]  RST_TYPE_HIGH        = 8'd6;
    localparam logic [31:0] RST_MAX_COMPRESSED   = 32'd65536;
    localparam logic [31:0] RST_MAX_UNCOMPRESSED = 32'd262144;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               magic_match;
        logic [7:0]         version;
        logic [7:0]         pkt_type;
        logic [15:0]        header_length;
        logic [31:0]        sequence_num;
        logic [15:0]        chunk_index;
        logic [15:0]        chunk_count;
        logic [31:0]        raw_size;
        logic [31:0]        packed_size;
        logic [15:0]        payload_length;
    } t_hdr;

    typedef struct packed {
        logic [7:0]  type_low;
        logic [7:0]  type_high;
        logic [31:0] max_compressed;
        logic [31:0] max_uncompressed;
    } t_cfg;

    localparam t_hdr HDR_CLEAR = '{
        byte_count:     '0,
        magic_match:    1'b1,
        version:        '0,
        pkt_type:       '0,
        header_length:  '0,
        sequence_num:   '0,
        chunk_index:    '0,
        chunk_count:    '0,
        raw_size:       '0,
        packed_size:    '0,
        payload_length: '0
    };

    // expected magic "DMPU", byte by byte
    function automatic logic [7:0] magic_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = 8'h44;
            2'd1:    b = 8'h4D;
            2'd2:    b = 8'h50;
            default: b = 8'h55;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/dhc_gather.sv -----
// byte counter and header field capture for one datagram
module dhc_gather (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output dhc_pkg::t_hdr  o_next_hdr
);

    dhc_pkg::t_hdr r_hdr;
    dhc_pkg::t_hdr n_hdr;

    logic [5:0] w_pos;

    assign w_pos = r_hdr.byte_count[5:0];

    always_comb begin
        n_hdr = r_hdr;
        if (r_hdr.byte_count < dhc_pkg::HDR_BYTES) begin
            case (w_pos)
                6'd0, 6'd1, 6'd2, 6'd3: begin
                    if (i_data_byte != dhc_pkg::magic_byte(w_pos[1:0])) begin
                        n_hdr.magic_match = 1'b0;
                    end
                end
                6'd4: n_hdr.version  = i_data_byte;
                6'd5: n_hdr.pkt_type = i_data_byte;
                6'd6, 6'd7: begin
                    n_hdr.header_length[{w_pos[0], 3'b000} +: 8] = i_data_byte;
                end
                6'd8, 6'd9, 6'd10, 6'd11: begin
                    n_hdr.sequence_num[{w_pos[1:0], 3'b000} +: 8] = i_data_byte;
                end
                6'd12, 6'd13: begin
                    n_hdr.chunk_index[{w_pos[0], 3'b000} +: 8] = i_data_byte;
                end
                6'd14, 6'd15: begin
                    n_hdr.chunk_count[{w_pos[0], 3'b000} +: 8] = i_data_byte;
                end
                6'd16, 6'd17, 6'd18, 6'd19: begin
                    n_hdr.raw_size[{w_pos[1:0], 3'b000} +: 8] = i_data_byte;
                end
                6'd20, 6'd21, 6'd22, 6'd23: begin
                    n_hdr.packed_size[{w_pos[1:0], 3'b000} +: 8] = i_data_byte;
                end
                6'd24, 6'd25: begin
                    n_hdr.payload_length[{w_pos[0], 3'b000} +: 8] = i_data_byte;
                end
                // sender id bytes are skipped
                default: ;
            endcase
        end
        if (r_hdr.byte_count != dhc_pkg::COUNT_MAX) begin
            n_hdr.byte_count = r_hdr.byte_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= dhc_pkg::HDR_CLEAR;
        end else if (i_accept) begin
            // last beat hands the fields on and starts a fresh datagram
            if (i_last_byte) begin
                r_hdr <= dhc_pkg::HDR_CLEAR;
            end else begin
                r_hdr <= n_hdr;
            end
        end
    end

    assign o_next_hdr = n_hdr;

endmodule

// ----- sv/dhc_check.sv -----
// header validity checks against the configured limits
module dhc_check (
    input  dhc_pkg::t_hdr  i_hdr,
    input  dhc_pkg::t_cfg  i_cfg,
    output logic           o_ok
);

    logic [dhc_pkg::COUNT_W-1:0] w_expected_len;

    assign w_expected_len = {1'b0, i_hdr.payload_length} + dhc_pkg::HDR_BYTES;

    assign o_ok = (i_hdr.byte_count >= dhc_pkg::HDR_BYTES)
                && i_hdr.magic_match
                && (i_hdr.version == dhc_pkg::HDR_VERSION)
                && (i_hdr.pkt_type >= i_cfg.type_low)
                && (i_hdr.pkt_type <= i_cfg.type_high)
                && (i_hdr.header_length == dhc_pkg::HDR_BYTES[15:0])
                && (i_hdr.payload_length != 16'd0)
                && (i_hdr.chunk_count != 16'd0)
                && (i_hdr.chunk_index <= i_hdr.chunk_count)
                && (i_hdr.packed_size != 32'd0)
                && (i_hdr.packed_size <= i_cfg.max_compressed)
                && (i_hdr.raw_size != 32'd0)
                && (i_hdr.raw_size <= i_cfg.max_uncompressed)
                && (i_hdr.byte_count == w_expected_len);

endmodule

// ----- sv/datagram_header_checker.sv -----
// top level: byte intake, header snapshot, verdict register and register port
//
// Takes one datagram byte per cycle with no gaps required between datagrams.
// The beat that carries the last-byte mark yields one verdict with the header
// fields: the gathered header is first captured into a snapshot register,
// and the field checks then run from that snapshot into the result
// register. Bytes without the mark produce no result. Input stalls only when
// both the snapshot and the result register are full and the result is held.
// Registers at byte addresses 0, 4, 8, 12: type_low, type_high,
// max_compressed, max_uncompressed; write them only while no datagram is in
// flight.
module datagram_header_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // verdict output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_valid_res,
    output logic [7:0]  o_packet_type,
    output logic [31:0] o_sequence_number,
    output logic [15:0] o_chunk_index,
    output logic [15:0] o_chunk_count,
    output logic [31:0] o_uncompressed_size,
    output logic [31:0] o_compressed_size,
    output logic [15:0] o_payload_size,
    output logic        o_is_parity,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dhc_pkg::t_cfg r_cfg;
    dhc_pkg::t_hdr w_next_hdr;
    dhc_pkg::t_hdr r_snap;
    logic          r_snap_vld;
    logic          r_out_vld;
    logic          w_in_acc;
    logic          w_snap_adv;
    logic          w_ok;
    logic          w_cfg_wr;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type_low         <= dhc_pkg::RST_TYPE_LOW;
            r_cfg.type_high        <= dhc_pkg::RST_TYPE_HIGH;
            r_cfg.max_compressed   <= dhc_pkg::RST_MAX_COMPRESSED;
            r_cfg.max_uncompressed <= dhc_pkg::RST_MAX_UNCOMPRESSED;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                dhc_pkg::REG_TYPE_LOW:         r_cfg.type_low <= pwdata[7:0];
                dhc_pkg::REG_TYPE_HIGH:        r_cfg.type_high <= pwdata[7:0];
                dhc_pkg::REG_MAX_COMPRESSED:   r_cfg.max_compressed <= pwdata;
                dhc_pkg::REG_MAX_UNCOMPRESSED: r_cfg.max_uncompressed <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dhc_pkg::REG_TYPE_LOW:         prdata = {24'd0, r_cfg.type_low};
            dhc_pkg::REG_TYPE_HIGH:        prdata = {24'd0, r_cfg.type_high};
            dhc_pkg::REG_MAX_COMPRESSED:   prdata = r_cfg.max_compressed;
            dhc_pkg::REG_MAX_UNCOMPRESSED: prdata = r_cfg.max_uncompressed;
            default:                       prdata = '0;
        endcase
    end

    // handshakes
    assign w_snap_adv = r_snap_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_snap_vld && !w_snap_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    dhc_gather u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_acc),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_next_hdr  (w_next_hdr)
    );

    // header snapshot taken on the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (w_in_acc && i_last_byte) begin
            r_snap_vld <= 1'b1;
        end else if (w_snap_adv) begin
            r_snap_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last_byte) begin
            r_snap <= w_next_hdr;
        end
    end

    dhc_check u_check (
        .i_hdr (r_snap),
        .i_cfg (r_cfg),
        .o_ok  (w_ok)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_snap_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_adv) begin
            o_valid_res         <= w_ok;
            o_packet_type       <= r_snap.pkt_type;
            o_sequence_number   <= r_snap.sequence_num;
            o_chunk_index       <= r_snap.chunk_index;
            o_chunk_count       <= r_snap.chunk_count;
            o_uncompressed_size <= r_snap.raw_size;
            o_compressed_size   <= r_snap.packed_size;
            o_payload_size      <= r_snap.payload_length;
            o_is_parity         <= (r_snap.chunk_index == r_snap.chunk_count);
        end
    end

    assign o_out_valid = r_out_vld;

    // checks
    a_last_fills_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_last_byte |=> r_snap_vld)
        else $error("last beat did not load the header snapshot");

    a_snap_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_adv |=> o_out_valid && (o_valid_res == $past(w_ok)))
        else $error("snapshot did not reach the result register");

    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_stall && !w_snap_adv |=> !o_out_valid)
        else $error("taken result was shown again");

endmodule
